FILE: hdl/imhm_pkg.sv
// ---------------------------------------------------------------------------
// imhm_pkg
// Shared types and constants for the indexed magnitude min-heap.
// ---------------------------------------------------------------------------
package imhm_pkg;

    localparam int unsigned DEF_CAPACITY = 256;
    localparam int unsigned DEF_ID_SPACE = 256;
    localparam int unsigned DEF_KEY_BITS = 32;

    localparam int unsigned ID_W      = 8;
    localparam int unsigned OP_W      = 2;
    localparam int unsigned STAT_W    = 2;
    localparam int unsigned CNT_OUT_W = 9;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT   = 2'd0,
        OP_POP      = 2'd1,
        OP_DECREASE = 2'd2,
        OP_PEEK     = 2'd3
    } opcode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_BAD_ID = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_DEC_CMP,
        S_UP,
        S_PLACE,
        S_DN_L,
        S_DN_R,
        S_RESULT
    } seq_state_t;

    typedef struct packed {
        logic start;
        logic out_free;
    } seq_ctl_t;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } seq_stat_t;

endpackage

FILE: hdl/imhm_mag_cmp.sv
// ---------------------------------------------------------------------------
// imhm_mag_cmp
// Shared magnitude comparator: a_lt_b when |a| < |b| as unsigned values.
// ---------------------------------------------------------------------------
module imhm_mag_cmp
    import imhm_pkg::*;
#(
    parameter int unsigned KEY_BITS = DEF_KEY_BITS
) (
    input  logic [KEY_BITS-1:0] a_key,
    input  logic [KEY_BITS-1:0] b_key,
    output logic                a_lt_b
);

    logic [KEY_BITS-1:0] a_mag;
    logic [KEY_BITS-1:0] b_mag;

    assign a_mag  = a_key[KEY_BITS-1] ? (~a_key + KEY_BITS'(1)) : a_key;
    assign b_mag  = b_key[KEY_BITS-1] ? (~b_key + KEY_BITS'(1)) : b_key;
    assign a_lt_b = a_mag < b_mag;

endmodule

FILE: hdl/imhm_seq.sv
// ---------------------------------------------------------------------------
// imhm_seq
// Heap store, slot map and the sequencer that sifts one level at a time
// through the shared comparator.
// ---------------------------------------------------------------------------
module imhm_seq
    import imhm_pkg::*;
#(
    parameter int unsigned CAPACITY = DEF_CAPACITY,
    parameter int unsigned ID_SPACE = DEF_ID_SPACE,
    parameter int unsigned KEY_BITS = DEF_KEY_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  seq_ctl_t             ctl,
    input  opcode_t              op,
    input  logic [ID_W-1:0]      id,
    input  logic [KEY_BITS-1:0]  key,
    output seq_stat_t            stat,
    output logic [ID_W-1:0]      res_id,
    output logic [KEY_BITS-1:0]  res_key,
    output status_t              res_status,
    output logic [CNT_OUT_W-1:0] res_count
);

    localparam int unsigned SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
    localparam int unsigned ID_DEPTH = (ID_SPACE < 256) ? ID_SPACE : 256;
    localparam int unsigned IDX_W    = $clog2(ID_DEPTH);
    localparam int unsigned LW       = SLOT_W + 2;

    logic [ID_W-1:0]     heap_id_mem  [CAPACITY];
    logic [KEY_BITS-1:0] heap_key_mem [CAPACITY];
    logic [SLOT_W-1:0]   map_mem      [ID_DEPTH];

    seq_state_t          state_reg, state_next;
    opcode_t             op_reg, op_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [ID_W-1:0]     e_id_reg, e_id_next;
    logic [KEY_BITS-1:0] e_key_reg, e_key_next;
    logic [SLOT_W-1:0]   hole_reg, hole_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [ID_DEPTH-1:0] valid_reg, valid_next;
    logic                best_sel_reg, best_sel_next;
    logic [KEY_BITS-1:0] best_key_reg, best_key_next;
    logic [ID_W-1:0]     res_id_reg, res_id_next;
    logic [KEY_BITS-1:0] res_key_reg, res_key_next;
    status_t             res_status_reg, res_status_next;

    logic [ID_W-1:0]     rd_id_a, rd_id_b;
    logic [KEY_BITS-1:0] rd_key_a, rd_key_b;
    logic [SLOT_W-1:0]   map_rd;
    logic [SLOT_W-1:0]   addr_a, addr_b;

    logic                wr_en;
    logic [SLOT_W-1:0]   wr_addr;
    logic [ID_W-1:0]     wr_id;
    logic [KEY_BITS-1:0] wr_key;
    logic                map_we;
    logic [IDX_W-1:0]    map_waddr;
    logic [SLOT_W-1:0]   map_wdata;

    logic [KEY_BITS-1:0] cmp_a, cmp_b;
    logic                cmp_lt;

    logic                id_oor, id_held, full, empty;
    logic [IDX_W-1:0]    id_idx;
    logic [LW-1:0]       l_idx, r_idx, cnt_ext;
    logic                l_in, r_in, slot_in;
    logic [SLOT_W-1:0]   parent_idx;

    imhm_mag_cmp #(.KEY_BITS(KEY_BITS)) u_cmp (
        .a_key  (cmp_a),
        .b_key  (cmp_b),
        .a_lt_b (cmp_lt)
    );

    assign id_idx     = id_reg[IDX_W-1:0];
    assign id_oor     = 32'(id_reg) >= 32'(ID_SPACE);
    assign id_held    = !id_oor && valid_reg[id_idx];
    assign full       = cnt_reg >= CNT_W'(CAPACITY);
    assign empty      = cnt_reg == '0;
    assign cnt_ext    = LW'(cnt_reg);
    assign l_idx      = LW'({hole_reg, 1'b1});
    assign r_idx      = LW'({hole_reg, 1'b0}) + LW'(2);
    assign l_in       = l_idx < cnt_ext;
    assign r_in       = r_idx < cnt_ext;
    assign slot_in    = LW'(hole_reg) < cnt_ext;
    assign parent_idx = SLOT_W'((hole_reg - SLOT_W'(1)) >> 1);

    always_comb begin
        case (state_reg)
            S_DEC_CMP: begin
                cmp_a = rd_key_a;
                cmp_b = key_reg;
            end
            S_UP: begin
                cmp_a = e_key_reg;
                cmp_b = rd_key_a;
            end
            S_DN_R: begin
                cmp_a = rd_key_b;
                cmp_b = best_key_reg;
            end
            default: begin
                cmp_a = rd_key_a;
                cmp_b = e_key_reg;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (ctl.start) state_next = S_DECODE;
            end
            S_DECODE: begin
                case (op_reg)
                    OP_INSERT: begin
                        if (full || id_oor || id_held) state_next = S_RESULT;
                        else if (empty)                state_next = S_PLACE;
                        else                           state_next = S_UP;
                    end
                    OP_DECREASE: begin
                        state_next = id_held ? S_DEC_CMP : S_RESULT;
                    end
                    OP_POP: begin
                        state_next = empty ? S_RESULT : S_DN_L;
                    end
                    default: begin
                        state_next = S_RESULT;
                    end
                endcase
            end
            S_DEC_CMP: begin
                if (!slot_in || cmp_lt)  state_next = S_RESULT;
                else if (hole_reg == '0) state_next = S_PLACE;
                else                     state_next = S_UP;
            end
            S_UP: begin
                if (!cmp_lt)               state_next = S_RESULT;
                else if (parent_idx == '0) state_next = S_PLACE;
            end
            S_PLACE: state_next = S_RESULT;
            S_DN_L:  state_next = S_DN_R;
            S_DN_R: begin
                if ((r_in && cmp_lt) || best_sel_reg) state_next = S_DN_L;
                else                                  state_next = S_RESULT;
            end
            S_RESULT: begin
                if (ctl.out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        op_next         = op_reg;
        id_next         = id_reg;
        key_next        = key_reg;
        e_id_next       = e_id_reg;
        e_key_next      = e_key_reg;
        hole_next       = hole_reg;
        cnt_next        = cnt_reg;
        valid_next      = valid_reg;
        best_sel_next   = best_sel_reg;
        best_key_next   = best_key_reg;
        res_id_next     = res_id_reg;
        res_key_next    = res_key_reg;
        res_status_next = res_status_reg;
        wr_en           = 1'b0;
        wr_addr         = hole_reg;
        wr_id           = e_id_reg;
        wr_key          = e_key_reg;
        map_we          = 1'b0;
        map_waddr       = e_id_reg[IDX_W-1:0];
        map_wdata       = hole_reg;
        case (state_reg)
            S_IDLE: begin
                if (ctl.start) begin
                    op_next         = op;
                    id_next         = id;
                    key_next        = key;
                    res_id_next     = '0;
                    res_key_next    = '0;
                    res_status_next = ST_OK;
                end
            end
            S_DECODE: begin
                case (op_reg)
                    OP_INSERT: begin
                        if (full) begin
                            res_status_next = ST_FULL;
                        end else if (id_oor || id_held) begin
                            res_status_next = ST_BAD_ID;
                        end else begin
                            valid_next[id_idx] = 1'b1;
                            cnt_next   = cnt_reg + CNT_W'(1);
                            e_id_next  = id_reg;
                            e_key_next = key_reg;
                            hole_next  = SLOT_W'(cnt_reg);
                        end
                    end
                    OP_DECREASE: begin
                        if (!id_held) res_status_next = ST_BAD_ID;
                        else          hole_next       = map_rd;
                    end
                    default: begin
                        if (empty) begin
                            res_status_next = ST_EMPTY;
                        end else begin
                            res_id_next  = rd_id_a;
                            res_key_next = rd_key_a;
                            if (op_reg == OP_POP) begin
                                valid_next[rd_id_a[IDX_W-1:0]] = 1'b0;
                                cnt_next   = cnt_reg - CNT_W'(1);
                                e_id_next  = rd_id_b;
                                e_key_next = rd_key_b;
                                hole_next  = '0;
                            end
                        end
                    end
                endcase
            end
            S_DEC_CMP: begin
                e_id_next  = id_reg;
                e_key_next = key_reg;
            end
            S_UP: begin
                if (cmp_lt) begin
                    wr_id     = rd_id_a;
                    wr_key    = rd_key_a;
                    map_waddr = rd_id_a[IDX_W-1:0];
                    hole_next = parent_idx;
                end
                wr_en  = 1'b1;
                map_we = 1'b1;
            end
            S_PLACE: begin
                wr_en  = 1'b1;
                map_we = 1'b1;
            end
            S_DN_L: begin
                if (l_in && cmp_lt) begin
                    best_sel_next = 1'b1;
                    best_key_next = rd_key_a;
                end else begin
                    best_sel_next = 1'b0;
                    best_key_next = e_key_reg;
                end
            end
            S_DN_R: begin
                if (r_in && cmp_lt) begin
                    wr_id     = rd_id_b;
                    wr_key    = rd_key_b;
                    map_waddr = rd_id_b[IDX_W-1:0];
                    hole_next = SLOT_W'(r_idx);
                end else if (best_sel_reg) begin
                    wr_id     = rd_id_a;
                    wr_key    = rd_key_a;
                    map_waddr = rd_id_a[IDX_W-1:0];
                    hole_next = SLOT_W'(l_idx);
                end
                wr_en  = 1'b1;
                map_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        addr_a = '0;
        addr_b = SLOT_W'(cnt_reg - CNT_W'(1));
        case (state_next)
            S_DEC_CMP: addr_a = hole_next;
            S_UP:      addr_a = SLOT_W'((hole_next - SLOT_W'(1)) >> 1);
            S_DN_L, S_DN_R: begin
                addr_a = SLOT_W'({hole_next, 1'b1});
                addr_b = SLOT_W'({hole_next, 1'b0} + (SLOT_W + 1)'(2));
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        stat.idle      = state_reg == S_IDLE;
        stat.res_valid = state_reg == S_RESULT;
        res_id         = res_id_reg;
        res_key        = res_key_reg;
        res_status     = res_status_reg;
        res_count      = CNT_OUT_W'(cnt_reg);
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            heap_id_mem[wr_addr]  <= wr_id;
            heap_key_mem[wr_addr] <= wr_key;
        end
        rd_id_a  <= heap_id_mem[addr_a];
        rd_key_a <= heap_key_mem[addr_a];
        rd_id_b  <= heap_id_mem[addr_b];
        rd_key_b <= heap_key_mem[addr_b];
    end

    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_mem[map_waddr] <= map_wdata;
        end
        map_rd <= map_mem[id[IDX_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            valid_reg <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        id_reg         <= id_next;
        key_reg        <= key_next;
        e_id_reg       <= e_id_next;
        e_key_reg      <= e_key_next;
        hole_reg       <= hole_next;
        best_sel_reg   <= best_sel_next;
        best_key_reg   <= best_key_next;
        res_id_reg     <= res_id_next;
        res_key_reg    <= res_key_next;
        res_status_reg <= res_status_next;
    end

endmodule

FILE: hdl/indexed_min_heap_by_magnitude.sv
// ---------------------------------------------------------------------------
// indexed_min_heap_by_magnitude
// Indexed binary min-heap ordered by key magnitude, with decrease-key.
// Peek and rejected words go straight to the result; insert climbs level by
// level; decrease is ignored when the new magnitude exceeds the current one,
// else it climbs; pop descends, comparing the left child and then the right
// child at each level, through the single shared magnitude comparator.
// One word at a time; the sequencer returns to idle as the result enters the
// output register. Reset empties the heap and the id map at once, no sweep.
// ---------------------------------------------------------------------------
module indexed_min_heap_by_magnitude
    import imhm_pkg::*;
#(
    parameter int unsigned CAPACITY = DEF_CAPACITY,
    parameter int unsigned ID_SPACE = DEF_ID_SPACE,
    parameter int unsigned KEY_BITS = DEF_KEY_BITS
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    // opcode, entry_id, key
    input  logic [((OP_W+ID_W+KEY_BITS+7)/8)*8-1:0]        s_tdata,
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    // out_id, out_key, status, count
    output logic [((ID_W+KEY_BITS+STAT_W+CNT_OUT_W+7)/8)*8-1:0] m_tdata
);

    localparam int unsigned M_W   = ((ID_W + KEY_BITS + STAT_W + CNT_OUT_W + 7) / 8) * 8;
    localparam int unsigned M_USE = ID_W + KEY_BITS + STAT_W + CNT_OUT_W;

    seq_ctl_t             ctl;
    seq_stat_t            stat;
    logic [ID_W-1:0]      res_id;
    logic [KEY_BITS-1:0]  res_key;
    status_t              res_status;
    logic [CNT_OUT_W-1:0] res_count;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_W-1:0]       m_tdata_reg, m_tdata_next;
    logic                 load;

    logic [ID_W-1:0]      m_id;
    logic [KEY_BITS-1:0]  m_key;
    logic [STAT_W-1:0]    m_status;
    logic [CNT_OUT_W-1:0] m_count;

    imhm_seq #(
        .CAPACITY (CAPACITY),
        .ID_SPACE (ID_SPACE),
        .KEY_BITS (KEY_BITS)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .op         (opcode_t'(s_tdata[OP_W-1:0])),
        .id         (s_tdata[OP_W +: ID_W]),
        .key        (s_tdata[OP_W+ID_W +: KEY_BITS]),
        .stat       (stat),
        .res_id     (res_id),
        .res_key    (res_key),
        .res_status (res_status),
        .res_count  (res_count)
    );

    assign s_tready     = stat.idle;
    assign ctl.start    = s_tvalid && stat.idle;
    assign ctl.out_free = !m_tvalid_reg || m_tready;
    assign load         = stat.res_valid && ctl.out_free;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = M_W'({res_count, res_status, res_key, res_id});
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign m_id     = m_tdata_reg[ID_W-1:0];
    assign m_key    = m_tdata_reg[ID_W +: KEY_BITS];
    assign m_status = m_tdata_reg[ID_W+KEY_BITS +: STAT_W];
    assign m_count  = m_tdata_reg[M_USE-1 -: CNT_OUT_W];

    a_one_word_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("word accepted while previous word in progress");

    a_empty_reports_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_status == ST_EMPTY)) |-> ((m_id == '0) && (m_key == '0)))
        else $error("empty result carries an entry");

    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (32'(m_count) <= 32'(CAPACITY)))
        else $error("entry count beyond capacity");

endmodule

FILE: sim/heap_checker.sv
// ---------------------------------------------------------------------------
// heap_checker
// Watches both streams of the indexed magnitude min-heap, keeps its own copy
// of the heap and id map, predicts each result and compares field by field.
// ---------------------------------------------------------------------------
module heap_checker
    import imhm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    output int          fail_count,
    output int          pending,
    output int          held
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0]  id;
        logic [31:0] key;
        status_t     status;
        logic [8:0]  count;
    } heap_result_t;

    logic [7:0]  slot_id  [256];
    logic [31:0] slot_key [256];
    int          pos_of   [256];
    bit          present  [256];
    int          n_held;
    heap_result_t expected_q[$];

    assign held    = n_held;

    function automatic logic [31:0] mag(logic [31:0] k);
        return k[31] ? (~k + 32'd1) : k;
    endfunction

    function automatic void swap_slots(int a, int b);
        logic [7:0]  ti;
        logic [31:0] tk;
        ti = slot_id[a];  tk = slot_key[a];
        slot_id[a] = slot_id[b];  slot_key[a] = slot_key[b];
        slot_id[b] = ti;  slot_key[b] = tk;
        pos_of[slot_id[a]] = a;
        pos_of[slot_id[b]] = b;
    endfunction

    function automatic void climb(int s);
        int p;
        while (s > 0) begin
            p = (s - 1) / 2;
            if (mag(slot_key[p]) > mag(slot_key[s])) begin
                swap_slots(s, p);
                s = p;
            end else begin
                break;
            end
        end
    endfunction

    function automatic void descend(int s);
        int l, r, best;
        forever begin
            l = 2 * s + 1;
            r = 2 * s + 2;
            best = s;
            if (l < n_held && mag(slot_key[l]) < mag(slot_key[s])) best = l;
            if (r < n_held && mag(slot_key[r]) < mag(slot_key[best])) best = r;
            if (best == s) break;
            swap_slots(best, s);
            s = best;
        end
    endfunction

    function automatic heap_result_t apply_op(opcode_t op, logic [7:0] id, logic [31:0] key);
        heap_result_t r;
        int s;
        r = '0;
        r.status = ST_OK;
        case (op)
            OP_INSERT: begin
                if (n_held >= 256) begin
                    r.status = ST_FULL;
                end else if (present[id]) begin
                    r.status = ST_BAD_ID;
                end else begin
                    s = n_held;
                    slot_id[s] = id;
                    slot_key[s] = key;
                    pos_of[id] = s;
                    present[id] = 1'b1;
                    n_held++;
                    climb(s);
                end
            end
            OP_DECREASE: begin
                if (!present[id]) begin
                    r.status = ST_BAD_ID;
                end else begin
                    s = pos_of[id];
                    if (mag(key) <= mag(slot_key[s])) begin
                        slot_key[s] = key;
                        climb(s);
                    end
                end
            end
            default: begin
                if (n_held == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.id = slot_id[0];
                    r.key = slot_key[0];
                    if (op == OP_POP) begin
                        s = n_held - 1;
                        swap_slots(0, s);
                        n_held--;
                        present[slot_id[s]] = 1'b0;
                        descend(0);
                    end
                end
            end
        endcase
        r.count = n_held[8:0];
        return r;
    endfunction

    task automatic report(string what, logic [39:0] got, logic [39:0] want);
        $display("tb: mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        pending = 0;
        n_held = 0;
        foreach (present[i]) present[i] = 1'b0;
    end

    always @(posedge aclk) begin
        heap_result_t got, want;
        if (aresetn && s_tvalid && s_tready)
            expected_q = {expected_q,
                          apply_op(opcode_t'(s_tdata[1:0]), s_tdata[9:2], s_tdata[41:10])};
        if (aresetn && m_tvalid && m_tready) begin
            got.id = m_tdata[7:0];
            got.key = m_tdata[39:8];
            got.status = status_t'(m_tdata[41:40]);
            got.count = m_tdata[50:42];
            if (expected_q.size() == 0) begin
                report("unexpected word", m_tdata[39:0], 40'd0);
            end else begin
                want = expected_q.pop_front();
                if (got.id !== want.id) report("out_id", got.id, want.id);
                if (got.key !== want.key) report("out_key", got.key, want.key);
                if (got.status !== want.status) report("status", got.status, want.status);
                if (got.count !== want.count) report("count", got.count, want.count);
            end
        end
        pending = expected_q.size();
    end
endmodule

FILE: sim/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Drives heap operations into the indexed magnitude min-heap: directed edge
// cases, then random fill and drain phases with random idling on both sides.
// ---------------------------------------------------------------------------
module testbench
    import imhm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG = 20000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    int          fail_count, pending, held;
    int          idle_cycles = 0;
    int          sink_wait = 0;
    int          n_ops = 0, n_pops = 0;
    bit          sink_hold = 1'b0;
    bit          no_gaps = 1'b0;

    always #4 aclk = ~aclk;

    indexed_min_heap_by_magnitude i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    heap_checker i_check (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending(pending), .held(held)
    );

    task automatic send_word(opcode_t op, logic [7:0] id, logic [31:0] key);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, key, id, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        n_ops++;
        if (op == OP_POP) n_pops++;
    endtask

    function automatic logic [31:0] rand_key();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'd0;
            3: return 32'($urandom_range(0, 15)) - 32'd8;
            default: return $urandom;
        endcase
    endfunction

    task automatic drain_wait();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // sink: hold tready low for a random number of cycles after each word
    always @(posedge aclk) begin
        if (!aresetn || sink_hold) begin
            m_tready <= 1'b0;
        end else if (m_tvalid && m_tready) begin
            sink_wait = no_gaps ? 0 : $urandom_range(0, 8);
            m_tready <= (sink_wait == 0);
        end else if (sink_wait > 0) begin
            sink_wait = sink_wait - 1;
            m_tready <= (sink_wait == 0);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int k, mode;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed
        send_word(OP_POP, 8'd0, 32'd0);
        send_word(OP_PEEK, 8'd0, 32'd0);
        send_word(OP_DECREASE, 8'd5, 32'd1);
        send_word(OP_INSERT, 8'd0, 32'h8000_0000);
        send_word(OP_INSERT, 8'd255, 32'h7fff_ffff);
        send_word(OP_INSERT, 8'd255, 32'd3);
        send_word(OP_INSERT, 8'd7, 32'hffff_fff0);
        send_word(OP_INSERT, 8'd8, 32'd16);
        send_word(OP_PEEK, 8'd0, 32'd0);
        send_word(OP_DECREASE, 8'd255, 32'hffff_ffff);
        send_word(OP_DECREASE, 8'd8, 32'hffff_fff0);
        send_word(OP_DECREASE, 8'd7, 32'd100);
        send_word(OP_DECREASE, 8'd0, 32'h8000_0000);
        send_word(OP_PEEK, 8'd0, 32'd0);
        repeat (5) send_word(OP_POP, 8'd0, 32'd0);
        // fill to capacity, overflow, then empty
        no_gaps = 1'b1;
        for (int i = 0; i < 256; i++) send_word(OP_INSERT, 8'(i), rand_key());
        send_word(OP_INSERT, 8'd3, 32'd1);
        send_word(OP_DECREASE, 8'd200, 32'd0);
        for (int i = 0; i < 257; i++) send_word(OP_POP, 8'd0, 32'd0);
        no_gaps = 1'b0;

        // hold the sender until all results are back, with the sink stalled a while
        s_tvalid <= 1'b0;
        sink_hold = 1'b1;
        repeat (30) @(posedge aclk);
        sink_hold = 1'b0;
        drain_wait();

        // random phases: fill-biased, drain-biased, mixed
        while (n_ops < 1650) begin
            mode = $urandom_range(0, 2);
            repeat (60) begin
                k = $urandom_range(0, 9);
                if ((mode == 0 && k < 6) || (mode == 2 && k < 4) || (mode == 1 && k < 2))
                    send_word(OP_INSERT, 8'($urandom), rand_key());
                else if (k < 7)
                    send_word(OP_POP, 8'($urandom), $urandom);
                else if (k < 9)
                    send_word(OP_DECREASE, 8'($urandom), rand_key());
                else
                    send_word(OP_PEEK, 8'($urandom), $urandom);
            end
            if ($urandom_range(0, 3) == 0) drain_wait();
        end

        drain_wait();
        repeat (50) @(posedge aclk);
        $display("tb: %0d operations sent, %0d of them pops, heap fill swept 0..256",
                 n_ops, n_pops);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
